// ===== sv/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the audio playout ring with resync.
// ----------------------------------------------------------------------------
package apr_pkg;

    // ring storage
    localparam int RING_DEPTH = 16384;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    // field widths
    localparam int POS_W    = 15;
    localparam int BLK_W    = 13;
    localparam int THR_W    = 20;
    localparam int SAMPLE_W = 16;
    localparam int DIST_W   = 32;
    localparam int MODN_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LEN        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LEN     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_THRESHOLD = 4'd3;

    // reset values of the registers
    localparam logic [POS_W-1:0] ARRAY_LEN_RST    = 15'd16384;
    localparam logic [BLK_W-1:0] BLOCK_LEN_RST    = 13'd256;
    localparam logic [BLK_W-1:0] INTERVAL_LEN_RST = 13'd2048;
    localparam logic [THR_W-1:0] THRESHOLD_RST    = 20'd6400;

    // distance saturation limits
    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] play_sample;
        logic                block_done;
        logic                resynced;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] array_len;
        logic [BLK_W-1:0] block_len;
        logic [BLK_W-1:0] interval_len;
        logic [THR_W-1:0] resync_threshold;
    } t_cfg;

    // classified command between front and back
    typedef struct packed {
        logic                is_read;
        logic [SAMPLE_W-1:0] sample;
    } t_cmd;

    // modulo unit request and response
    typedef struct packed {
        logic              start;
        logic [MODN_W-1:0] dividend;
        logic [POS_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [MODN_W-1:0] rem;
    } t_mod_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WCOLL,
        ST_RADDR,
        ST_RDATA,
        ST_RSYNC
    } t_state;

endpackage

// ===== sv/apr_front.sv =====
// ----------------------------------------------------------------------------
// apr_front
// Accepts input transactions, classifies them and holds them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module apr_front
    import apr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_hold,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    // classify the incoming item
    always_comb begin
        cmd_in.is_read = (i_in_item.operation == OP_READ);
        cmd_in.sample  = i_in_item.sample_in;
    end

    assign o_in_stall  = (r_count == 2'd2) || i_hold;
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue pointers
    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== sv/apr_mod.sv =====
// ----------------------------------------------------------------------------
// apr_mod
// Remainder unit: one compare-subtract when the dividend is below twice the
// divisor, otherwise a restoring pass of one bit per cycle.
// ----------------------------------------------------------------------------
module apr_mod
    import apr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    localparam int CNT_W = $clog2(MODN_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MODN_W-1:0] r_num;
    logic [MODN_W-1:0] r_rem;
    logic              n_busy;
    logic              n_done;
    logic [CNT_W-1:0]  n_cnt;
    logic [MODN_W-1:0] n_num;
    logic [MODN_W-1:0] n_rem;
    logic [MODN_W:0]   div_ext;
    logic [MODN_W:0]   div_twice;
    logic [MODN_W-1:0] trial;

    assign div_ext   = {{(MODN_W+1-POS_W){1'b0}}, i_req.divisor};
    assign div_twice = {div_ext[MODN_W-1:0], 1'b0};
    assign trial     = {r_rem[MODN_W-2:0], r_num[MODN_W-1]};

    // start or one restoring step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        if (i_req.start) begin
            if ({1'b0, i_req.dividend} < div_ext) begin
                n_rem  = i_req.dividend;
                n_done = 1'b1;
            end else if ({1'b0, i_req.dividend} < div_twice) begin
                n_rem  = i_req.dividend - div_ext[MODN_W-1:0];
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_num  = i_req.dividend;
                n_rem  = '0;
                n_cnt  = CNT_W'(MODN_W - 1);
            end
        end else if (r_busy) begin
            n_num = {r_num[MODN_W-2:0], 1'b0};
            n_rem = ({1'b0, trial} >= div_ext) ? trial - div_ext[MODN_W-1:0] : trial;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== sv/apr_back.sv =====
// ----------------------------------------------------------------------------
// apr_back
// Executes queued commands: sample store, ring positions, block bookkeeping,
// resync and the result register. Clears the store after reset.
// ----------------------------------------------------------------------------
module apr_back
    import apr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0]   r_clr_addr;
    logic [POS_W-1:0]    r_read_pos;
    logic [POS_W-1:0]    r_write_pos;
    logic [BLK_W-1:0]    r_block_offset;
    logic [DIST_W-1:0]   r_fill;
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_out_valid;
    t_out_item           r_out_item;
    t_out_item           r_pend;
    logic [SAMPLE_W-1:0] r_mem [RING_DEPTH];

    logic [ADDR_W-1:0]   n_clr_addr;
    logic [POS_W-1:0]    n_read_pos;
    logic [POS_W-1:0]    n_write_pos;
    logic [BLK_W-1:0]    n_block_offset;
    logic [DIST_W-1:0]   n_fill;
    logic                n_out_valid;
    t_out_item           n_out_item;
    t_out_item           n_pend;

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [SAMPLE_W-1:0] mem_wdata;
    t_mod_req            mod_req;
    t_mod_rsp            mod_rsp;

    logic [POS_W-1:0]    len;
    logic [BLK_W-1:0]    blk;
    logic [POS_W-1:0]    wp0;
    logic                collide;
    logic                out_free;
    logic [DIST_W-1:0]   fill_inc;
    logic [POS_W-1:0]    wr_target;
    logic [POS_W:0]      wr_plus;
    logic [POS_W-1:0]    wr_next;
    logic [BLK_W:0]      off_plus;
    logic                blk_end;
    logic [POS_W:0]      rp_adv;
    logic [POS_W+1:0]    rp_chk;
    logic [POS_W-1:0]    rp_new;
    logic [POS_W:0]      rp_new_end;
    logic                wr_in_block;
    logic [DIST_W:0]     fill_sub;
    logic [DIST_W-1:0]   fill_dec;
    logic                over_thr;
    logic                resync;

    // clamped ring and block length
    always_comb begin
        if (i_cfg.array_len == '0) begin
            len = POS_W'(1);
        end else if ({17'd0, i_cfg.array_len} > RING_DEPTH) begin
            len = POS_W'(RING_DEPTH);
        end else begin
            len = i_cfg.array_len;
        end
        blk = (i_cfg.block_len == '0) ? BLK_W'(1) : i_cfg.block_len;
    end

    // write side arithmetic
    assign wp0      = (r_write_pos >= len) ? '0 : r_write_pos;
    assign collide  = (wp0 == r_read_pos);
    assign fill_inc = (r_fill == DIST_MAX) ? r_fill : r_fill + 1'b1;
    assign wr_target = (r_state == ST_WCOLL) ? mod_rsp.rem[POS_W-1:0] : wp0;
    assign wr_plus  = {1'b0, wr_target} + 1'b1;
    assign wr_next  = (wr_plus >= {1'b0, len}) ? '0 : wr_plus[POS_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    // block end arithmetic
    always_comb begin
        off_plus    = {1'b0, r_block_offset} + 1'b1;
        blk_end     = (off_plus >= {1'b0, blk});
        rp_adv      = {1'b0, r_read_pos} + {3'b0, blk};
        rp_chk      = {1'b0, rp_adv} + {4'b0, blk};
        rp_new      = (rp_chk >= {2'b0, len}) ? '0 : rp_adv[POS_W-1:0];
        rp_new_end  = {1'b0, rp_new} + {3'b0, blk};
        wr_in_block = ({1'b0, r_write_pos} < rp_new_end) && (r_write_pos >= rp_new);
        fill_sub    = {r_fill[DIST_W-1], r_fill} - {20'b0, blk};
        fill_dec    = (fill_sub[DIST_W] != fill_sub[DIST_W-1]) ? DIST_MIN
                                                               : fill_sub[DIST_W-1:0];
        over_thr    = $signed(fill_dec) > $signed({12'b0, i_cfg.resync_threshold});
        resync      = blk_end && (wr_in_block || over_thr);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(RING_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_read) n_state = ST_RADDR;
                    else if (collide) n_state = ST_WCOLL;
                end
            end
            ST_WCOLL: begin
                if (mod_rsp.done) n_state = ST_IDLE;
            end
            ST_RADDR: begin
                if (mod_rsp.done) n_state = ST_RDATA;
            end
            ST_RDATA: begin
                if (out_free) n_state = resync ? ST_RSYNC : ST_IDLE;
            end
            ST_RSYNC: begin
                if (mod_rsp.done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_clr_addr     = r_clr_addr;
        n_read_pos     = r_read_pos;
        n_write_pos    = r_write_pos;
        n_block_offset = r_block_offset;
        n_fill         = r_fill;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_item     = r_out_item;
        n_pend         = r_pend;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = wr_target[ADDR_W-1:0];
        mem_wdata      = i_cmd.sample;
        mod_req        = '{start: 1'b0, dividend: '0, divisor: len};
        o_pop          = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_read) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = {1'b0, r_read_pos} + {3'b0, r_block_offset};
                    end else if (collide) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = {1'b0, r_read_pos} + {3'b0, blk};
                    end else begin
                        mem_we      = 1'b1;
                        n_write_pos = wr_next;
                        n_fill      = fill_inc;
                        o_pop       = 1'b1;
                    end
                end
            end
            ST_WCOLL: begin
                if (mod_rsp.done) begin
                    mem_we      = 1'b1;
                    n_write_pos = wr_next;
                    n_fill      = fill_inc;
                    o_pop       = 1'b1;
                end
            end
            ST_RADDR: begin
                if (mod_rsp.done) begin
                    mem_re   = 1'b1;
                    mem_addr = mod_rsp.rem[ADDR_W-1:0];
                end
            end
            ST_RDATA: begin
                if (out_free) begin
                    n_pend.play_sample = r_rdata;
                    n_pend.block_done  = blk_end;
                    n_pend.resynced    = resync;
                    if (blk_end) begin
                        n_block_offset = '0;
                        n_read_pos     = rp_new;
                        n_fill         = fill_dec;
                    end else begin
                        n_block_offset = off_plus[BLK_W-1:0];
                    end
                    if (resync) begin
                        n_fill           = {19'b0, i_cfg.interval_len};
                        mod_req.start    = 1'b1;
                        mod_req.dividend = {1'b0, rp_new} + {3'b0, i_cfg.interval_len};
                    end else begin
                        n_out_valid           = 1'b1;
                        n_out_item.play_sample = r_rdata;
                        n_out_item.block_done  = blk_end;
                        n_out_item.resynced    = 1'b0;
                        o_pop                  = 1'b1;
                    end
                end
            end
            ST_RSYNC: begin
                if (mod_rsp.done) begin
                    n_write_pos = mod_rsp.rem[POS_W-1:0];
                    n_out_valid = 1'b1;
                    n_out_item  = r_pend;
                    o_pop       = 1'b1;
                end
            end
            default: begin
                n_clr_addr = r_clr_addr;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_read_pos     <= '0;
            r_write_pos    <= {2'b0, INTERVAL_LEN_RST};
            r_block_offset <= '0;
            r_fill         <= {19'b0, INTERVAL_LEN_RST};
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_read_pos     <= n_read_pos;
            r_write_pos    <= n_write_pos;
            r_block_offset <= n_block_offset;
            r_fill         <= n_fill;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_pend     <= n_pend;
    end

    // sample store, single port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_addr];
    end

    apr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // no command retired while the store is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("command retired during clearing pass");

    // a retired command was present in the queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_cmd_valid)
        else $error("pop from empty command queue");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_item)))
        else $error("pending result changed");

    // remainder results arrive only in a waiting state
    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> (r_state == ST_WCOLL || r_state == ST_RADDR ||
                          r_state == ST_RSYNC))
        else $error("remainder result in unexpected state");

endmodule

// ===== sv/audio_playout_ring_resync.sv =====
// ----------------------------------------------------------------------------
// audio_playout_ring_resync
// Audio playout ring buffer with writer resync at block ends.
// Sequencing: a write is stored and retired from the queue when the back end
//   is idle, after the remainder unit when the writer collides with the reader.
// A read goes through the remainder unit, a registered store read and the
//   result register; a resync block end adds a remainder pass before the result.
// Throughput: one item at a time in the back end, set by the remainder unit
//   and the single store port; a two-entry queue takes items meanwhile.
// Reset: a clearing pass zeroes the store, inputs stalled.
// ----------------------------------------------------------------------------
module audio_playout_ring_resync
    import apr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic pop;
    logic clearing;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.array_len        <= ARRAY_LEN_RST;
            r_cfg.block_len        <= BLOCK_LEN_RST;
            r_cfg.interval_len     <= INTERVAL_LEN_RST;
            r_cfg.resync_threshold <= THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ARRAY_LEN:        r_cfg.array_len        <= i_cfg_data[POS_W-1:0];
                CFG_BLOCK_LEN:        r_cfg.block_len        <= i_cfg_data[BLK_W-1:0];
                CFG_INTERVAL_LEN:     r_cfg.interval_len     <= i_cfg_data[BLK_W-1:0];
                CFG_RESYNC_THRESHOLD: r_cfg.resync_threshold <= i_cfg_data[THR_W-1:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    apr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_hold      (clearing),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    apr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
